/* hw/rtl/apm_pkg.sv */
// Shared types, constants and tables for the audio peak meter.
package apm_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 24;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXP_W  = $clog2(SAMPLE_BITS);
  localparam int MANT_W = 5;
  localparam int LOG_W  = 11;
  localparam int SC_W   = EXP_W + LOG_W;
  localparam int L256_W = SC_W + 1;
  localparam int DIFF_W = L256_W + 1;
  localparam int LVL_W  = 12;
  localparam int DEF_W  = 13;
  localparam int SEG_W  = 6;
  localparam int PROD_W = DEF_W + SEG_W;
  localparam int AGE_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_LEVEL   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_TICKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_METER_WIDTH = 2'd2;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  localparam logic signed [LVL_W-1:0] REF_LEVEL_RST   = '0;
  localparam logic [AGE_W-1:0]        DECAY_TICKS_RST = 8'd12;
  localparam logic [SEG_W-1:0]        METER_WIDTH_RST = 6'd20;

  localparam logic signed [LVL_W-1:0] LVL_MIN = {1'b1, {(LVL_W-1){1'b0}}};
  localparam logic signed [LVL_W-1:0] LVL_MAX = {1'b0, {(LVL_W-1){1'b1}}};

  // 1/256 dB per octave of the peak
  localparam int DB256_PER_BIT = 1541;

  // floor(x / 25) == (x * 1311) >> 15 for x below 1600
  localparam int RECIP_25    = 1311;
  localparam int RECIP_SHIFT = 15;
  localparam int RECIP_W     = 11;
  localparam int PCT_SHIFT   = 8;

  localparam logic [LOG_W-1:0] LOG_TAB [32] = '{
    11'd0,    11'd68,   11'd135,  11'd199,  11'd262,  11'd323,  11'd382,  11'd440,
    11'd496,  11'd551,  11'd605,  11'd657,  11'd708,  11'd758,  11'd807,  11'd855,
    11'd902,  11'd947,  11'd992,  11'd1036, 11'd1080, 11'd1122, 11'd1163, 11'd1204,
    11'd1244, 11'd1284, 11'd1322, 11'd1360, 11'd1398, 11'd1435, 11'd1471, 11'd1506
  };

  typedef struct packed {
    logic signed [LVL_W-1:0] ref_level;
    logic [AGE_W-1:0]        decay_ticks;
    logic [SEG_W-1:0]        meter_width;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]         ch;
    logic signed [LVL_W-1:0] lvl;
  } meter_t;

endpackage

/* hw/rtl/audio_peak_meter_iec_scale_core.sv */
// A tick item's result passes through seven register stages after it is accepted: capture,
// encode, level, deflection, width product, bar, hold marker.
// Throughput: one item per cycle while out_stall_i does not back up the pipeline.
// Sample items update the channel peak and produce no result.
// Reset clears all peaks, hold markers and hold ages and loads the default
// configuration; the block accepts items in the first cycle after reset.
module audio_peak_meter_iec_scale_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   func_i,
  input  logic [apm_pkg::CH_W-1:0]               channel_i,
  input  logic signed [apm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [apm_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [apm_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [apm_pkg::CH_W-1:0]               out_channel_o,
  output logic signed [apm_pkg::LVL_W-1:0]       level_db_o,
  output logic [apm_pkg::SEG_W-1:0]              bar_length_o,
  output logic [apm_pkg::SEG_W-1:0]              hold_position_o
);

  apm_pkg::cfg_t                    cfg_q;
  logic                             accept;
  logic                             en1;
  logic                             en2;
  logic                             en4;
  logic                             en7;
  logic                             v1;
  logic [apm_pkg::CH_W-1:0]         ch1;
  logic [apm_pkg::SAMPLE_BITS-1:0]  peak1;
  logic                             v3;
  apm_pkg::meter_t                  meter3;
  logic                             v6;
  apm_pkg::meter_t                  meter6;
  logic [apm_pkg::SEG_W-1:0]        bar6;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !en1;
  assign accept      = in_valid_i && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_level   <= apm_pkg::REF_LEVEL_RST;
      cfg_q.decay_ticks <= apm_pkg::DECAY_TICKS_RST;
      cfg_q.meter_width <= apm_pkg::METER_WIDTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        apm_pkg::CFG_REF_LEVEL:   cfg_q.ref_level   <= cfg_data_i[apm_pkg::LVL_W-1:0];
        apm_pkg::CFG_DECAY_TICKS: cfg_q.decay_ticks <= cfg_data_i[apm_pkg::AGE_W-1:0];
        apm_pkg::CFG_METER_WIDTH: cfg_q.meter_width <= cfg_data_i[apm_pkg::SEG_W-1:0];
        default: ;
      endcase
    end
  end

  apm_peak u_peak (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .func_i    (func_i),
    .channel_i (channel_i),
    .sample_i  (sample_i),
    .en_next_i (en2),
    .en_o      (en1),
    .valid_o   (v1),
    .ch_o      (ch1),
    .peak_o    (peak1)
  );

  apm_level u_level (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v1),
    .ch_i        (ch1),
    .peak_i      (peak1),
    .ref_level_i (cfg_q.ref_level),
    .en_next_i   (en4),
    .en_o        (en2),
    .valid_o     (v3),
    .meter_o     (meter3)
  );

  apm_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (v3),
    .meter_i       (meter3),
    .meter_width_i (cfg_q.meter_width),
    .en_next_i     (en7),
    .en_o          (en4),
    .valid_o       (v6),
    .meter_o       (meter6),
    .bar_o         (bar6)
  );

  apm_hold u_hold (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (v6),
    .meter_i         (meter6),
    .bar_i           (bar6),
    .decay_ticks_i   (cfg_q.decay_ticks),
    .meter_width_i   (cfg_q.meter_width),
    .stall_i         (out_stall_i),
    .en_o            (en7),
    .valid_o         (out_valid_o),
    .channel_o       (out_channel_o),
    .level_db_o      (level_db_o),
    .bar_length_o    (bar_length_o),
    .hold_position_o (hold_position_o)
  );

endmodule

/* hw/rtl/apm_peak.sv */
// Per-channel running peak registers and tick capture stage.
module apm_peak (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  accept_i,
  input  logic                                  func_i,
  input  logic [apm_pkg::CH_W-1:0]              channel_i,
  input  logic signed [apm_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                  en_next_i,
  output logic                                  en_o,
  output logic                                  valid_o,
  output logic [apm_pkg::CH_W-1:0]              ch_o,
  output logic [apm_pkg::SAMPLE_BITS-1:0]       peak_o
);

  logic [apm_pkg::SAMPLE_BITS-1:0] peak_q [apm_pkg::CHANNELS];
  logic [apm_pkg::SAMPLE_BITS-1:0] mag;
  logic [apm_pkg::SAMPLE_BITS-1:0] cur;
  logic [apm_pkg::SAMPLE_BITS-1:0] cap_q;
  logic [apm_pkg::CH_W-1:0]        ch_q;
  logic                            valid_q;
  logic                            ch_ok;
  logic                            is_tick;

  assign ch_ok   = 32'(channel_i) < apm_pkg::CHANNELS;
  assign is_tick = (func_i == apm_pkg::FUNC_TICK);
  assign cur     = peak_q[channel_i];
  assign mag     = sample_i[apm_pkg::SAMPLE_BITS-1] ?
                   apm_pkg::SAMPLE_BITS'(-sample_i) : apm_pkg::SAMPLE_BITS'(sample_i);
  assign en_o    = !valid_q || en_next_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < apm_pkg::CHANNELS; i++) begin
        peak_q[i] <= '0;
      end
    end else begin
      if (en_o) begin
        valid_q <= accept_i && is_tick && ch_ok;
      end
      if (accept_i && ch_ok) begin
        if (is_tick) begin
          peak_q[channel_i] <= '0;
        end else if (mag > cur) begin
          peak_q[channel_i] <= mag;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && accept_i) begin
      ch_q  <= channel_i;
      cap_q <= cur;
    end
  end

  assign valid_o = valid_q;
  assign ch_o    = ch_q;
  assign peak_o  = cap_q;

endmodule

/* hw/rtl/apm_level.sv */
// Peak to dB conversion: priority encoder, log table, reference and saturation.
module apm_level (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  logic [apm_pkg::CH_W-1:0]        ch_i,
  input  logic [apm_pkg::SAMPLE_BITS-1:0] peak_i,
  input  logic signed [apm_pkg::LVL_W-1:0] ref_level_i,
  input  logic                            en_next_i,
  output logic                            en_o,
  output logic                            valid_o,
  output apm_pkg::meter_t                 meter_o
);

  logic                               v2_q;
  logic                               v3_q;
  logic                               en2;
  logic                               en3;
  logic [apm_pkg::EXP_W-1:0]          e;
  logic [apm_pkg::SAMPLE_BITS-1:0]    norm;
  logic [apm_pkg::EXP_W-1:0]          e2_q;
  logic [apm_pkg::MANT_W-1:0]         m2_q;
  logic                               z2_q;
  logic [apm_pkg::CH_W-1:0]           ch2_q;
  logic [apm_pkg::SC_W-1:0]           sc;
  logic signed [apm_pkg::L256_W-1:0]  lvl256;
  logic signed [apm_pkg::L256_W-1:0]  lvl16;
  logic signed [apm_pkg::L256_W-1:0]  base;
  logic signed [apm_pkg::DIFF_W-1:0]  diff;
  logic signed [apm_pkg::LVL_W-1:0]   lvl_d;
  apm_pkg::meter_t                    meter_q;

  assign en3  = !v3_q || en_next_i;
  assign en2  = !v2_q || en3;
  assign en_o = en2;

  always_comb begin
    e = '0;
    for (int i = 0; i < apm_pkg::SAMPLE_BITS; i++) begin
      if (peak_i[i]) begin
        e = apm_pkg::EXP_W'(i);
      end
    end
  end

  assign norm = peak_i << (apm_pkg::EXP_W'(apm_pkg::SAMPLE_BITS - 1) - e);

  assign sc     = apm_pkg::SC_W'(apm_pkg::EXP_W'(apm_pkg::SAMPLE_BITS - 1) - e2_q)
                * apm_pkg::SC_W'(apm_pkg::DB256_PER_BIT);
  assign lvl256 = signed'(apm_pkg::L256_W'(apm_pkg::LOG_TAB[m2_q]))
                - signed'(apm_pkg::L256_W'(sc));
  assign lvl16  = lvl256 >>> 4;
  assign base   = z2_q ? apm_pkg::L256_W'(apm_pkg::LVL_MIN) : lvl16;
  assign diff   = apm_pkg::DIFF_W'(base) - apm_pkg::DIFF_W'(ref_level_i);

  always_comb begin
    if (diff < apm_pkg::DIFF_W'(apm_pkg::LVL_MIN)) begin
      lvl_d = apm_pkg::LVL_MIN;
    end else if (diff > apm_pkg::DIFF_W'(apm_pkg::LVL_MAX)) begin
      lvl_d = apm_pkg::LVL_MAX;
    end else begin
      lvl_d = apm_pkg::LVL_W'(diff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && valid_i) begin
      e2_q  <= e;
      m2_q  <= norm[apm_pkg::SAMPLE_BITS-2 -: apm_pkg::MANT_W];
      z2_q  <= (peak_i == '0);
      ch2_q <= ch_i;
    end
    if (en3 && v2_q) begin
      meter_q.ch  <= ch2_q;
      meter_q.lvl <= lvl_d;
    end
  end

  assign valid_o = v3_q;
  assign meter_o = meter_q;

endmodule

/* hw/rtl/apm_scale.sv */
// IEC deflection curve and scaling of the deflection to bar segments.
module apm_scale (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  apm_pkg::meter_t           meter_i,
  input  logic [apm_pkg::SEG_W-1:0] meter_width_i,
  input  logic                      en_next_i,
  output logic                      en_o,
  output logic                      valid_o,
  output apm_pkg::meter_t           meter_o,
  output logic [apm_pkg::SEG_W-1:0] bar_o
);

  localparam int RP_W = apm_pkg::RECIP_W + apm_pkg::RECIP_W;

  logic                        v4_q;
  logic                        v5_q;
  logic                        v6_q;
  logic                        en4;
  logic                        en5;
  logic                        en6;
  apm_pkg::meter_t             m4_q;
  apm_pkg::meter_t             m5_q;
  apm_pkg::meter_t             m6_q;
  logic [apm_pkg::DEF_W-1:0]   def4_q;
  logic [apm_pkg::PROD_W-1:0]  prod5_q;
  logic [apm_pkg::SEG_W-1:0]   bar6_q;
  logic [RP_W-1:0]             rp;

  // deflection in 1/64 percent
  function automatic logic [apm_pkg::DEF_W-1:0] deflect(
    input logic signed [apm_pkg::LVL_W-1:0] d
  );
    logic signed [15:0] x;
    logic signed [15:0] v;
    x = 16'(d);
    if (x < -16'sd1120) begin
      v = 16'sd0;
    end else if (x < -16'sd960) begin
      v = x + 16'sd1120;
    end else if (x < -16'sd800) begin
      v = (x + 16'sd960) * 16'sd2 + 16'sd160;
    end else if (x < -16'sd640) begin
      v = (x + 16'sd800) * 16'sd3 + 16'sd480;
    end else if (x < -16'sd480) begin
      v = (x + 16'sd640) * 16'sd6 + 16'sd960;
    end else if (x < -16'sd320) begin
      v = (x + 16'sd480) * 16'sd8 + 16'sd1920;
    end else if (x < 16'sd0) begin
      v = (x + 16'sd320) * 16'sd10 + 16'sd3200;
    end else begin
      v = 16'sd6400;
    end
    return apm_pkg::DEF_W'(v);
  endfunction

  assign en6  = !v6_q || en_next_i;
  assign en5  = !v5_q || en6;
  assign en4  = !v4_q || en5;
  assign en_o = en4;

  // floor(prod / 6400) as floor(floor(prod / 256) / 25)
  assign rp = RP_W'(prod5_q[apm_pkg::PROD_W-1:apm_pkg::PCT_SHIFT])
            * RP_W'(apm_pkg::RECIP_25);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (en4) begin
        v4_q <= valid_i;
      end
      if (en5) begin
        v5_q <= v4_q;
      end
      if (en6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid_i) begin
      m4_q   <= meter_i;
      def4_q <= deflect(meter_i.lvl);
    end
    if (en5 && v4_q) begin
      m5_q    <= m4_q;
      prod5_q <= apm_pkg::PROD_W'(def4_q) * apm_pkg::PROD_W'(meter_width_i);
    end
    if (en6 && v5_q) begin
      m6_q   <= m5_q;
      bar6_q <= rp[apm_pkg::RECIP_SHIFT +: apm_pkg::SEG_W];
    end
  end

  assign valid_o = v6_q;
  assign meter_o = m6_q;
  assign bar_o   = bar6_q;

endmodule

/* hw/rtl/apm_hold.sv */
// Peak-hold marker state per channel and the result register.
module apm_hold (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  apm_pkg::meter_t                  meter_i,
  input  logic [apm_pkg::SEG_W-1:0]        bar_i,
  input  logic [apm_pkg::AGE_W-1:0]        decay_ticks_i,
  input  logic [apm_pkg::SEG_W-1:0]        meter_width_i,
  input  logic                             stall_i,
  output logic                             en_o,
  output logic                             valid_o,
  output logic [apm_pkg::CH_W-1:0]         channel_o,
  output logic signed [apm_pkg::LVL_W-1:0] level_db_o,
  output logic [apm_pkg::SEG_W-1:0]        bar_length_o,
  output logic [apm_pkg::SEG_W-1:0]        hold_position_o
);

  logic [apm_pkg::SEG_W-1:0]        seg_q [apm_pkg::CHANNELS];
  logic [apm_pkg::AGE_W-1:0]        age_q [apm_pkg::CHANNELS];
  logic [apm_pkg::SEG_W-1:0]        seg;
  logic [apm_pkg::AGE_W-1:0]        age;
  logic [apm_pkg::SEG_W-1:0]        seg_d;
  logic [apm_pkg::AGE_W-1:0]        age_d;
  logic [apm_pkg::SEG_W-1:0]        hold_d;
  logic                             valid_q;
  logic [apm_pkg::CH_W-1:0]         ch_q;
  logic signed [apm_pkg::LVL_W-1:0] lvl_q;
  logic [apm_pkg::SEG_W-1:0]        bar_q;
  logic [apm_pkg::SEG_W-1:0]        hold_q;

  assign en_o = !valid_q || !stall_i;
  assign seg  = seg_q[meter_i.ch];
  assign age  = age_q[meter_i.ch];

  always_comb begin
    if (bar_i > seg) begin
      seg_d = bar_i;
      age_d = '0;
    end else begin
      seg_d = (age > decay_ticks_i) ? bar_i : seg;
      age_d = (age == '1) ? age : age + 1'b1;
    end
    hold_d = (seg_d > meter_width_i) ? meter_width_i : seg_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      for (int i = 0; i < apm_pkg::CHANNELS; i++) begin
        seg_q[i] <= '0;
        age_q[i] <= '0;
      end
    end else if (en_o) begin
      valid_q <= valid_i;
      if (valid_i) begin
        seg_q[meter_i.ch] <= seg_d;
        age_q[meter_i.ch] <= age_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && valid_i) begin
      ch_q   <= meter_i.ch;
      lvl_q  <= meter_i.lvl;
      bar_q  <= bar_i;
      hold_q <= hold_d;
    end
  end

  assign valid_o         = valid_q;
  assign channel_o       = ch_q;
  assign level_db_o      = lvl_q;
  assign bar_length_o    = bar_q;
  assign hold_position_o = hold_q;

endmodule

/* test/audio_peak_meter_iec_scale_core_tb.sv */
// Self-checking testbench for the two-channel IEC-scale peak meter core.
module audio_peak_meter_iec_scale_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                                   func;
    logic [apm_pkg::CH_W-1:0]               ch;
    logic signed [apm_pkg::SAMPLE_BITS-1:0] sample;
  } meter_item_t;

  typedef struct packed {
    logic [apm_pkg::CH_W-1:0]         ch;
    logic signed [apm_pkg::LVL_W-1:0] lvl;
    logic [apm_pkg::SEG_W-1:0]        bar;
    logic [apm_pkg::SEG_W-1:0]        hold;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic                                   in_func = apm_pkg::FUNC_SAMPLE;
  logic [apm_pkg::CH_W-1:0]               in_chan = '0;
  logic signed [apm_pkg::SAMPLE_BITS-1:0] in_sample = '0;
  logic                                   cfg_valid = 1'b0;
  logic                                   cfg_ready;
  logic [apm_pkg::CFG_IDX_W-1:0]          cfg_index = apm_pkg::CFG_REF_LEVEL;
  logic [apm_pkg::CFG_DATA_W-1:0]         cfg_data = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic [apm_pkg::CH_W-1:0]               out_chan;
  logic signed [apm_pkg::LVL_W-1:0]       level_db;
  logic [apm_pkg::SEG_W-1:0]              bar_len;
  logic [apm_pkg::SEG_W-1:0]              hold_pos;

  // 1/256 dB log of the 5-bit mantissa below the msb
  int log_db256 [32] = '{
    0, 68, 135, 199, 262, 323, 382, 440,
    496, 551, 605, 657, 708, 758, 807, 855,
    902, 947, 992, 1036, 1080, 1122, 1163, 1204,
    1244, 1284, 1322, 1360, 1398, 1435, 1471, 1506
  };

  // meter state and settings as the core should hold them
  logic [apm_pkg::SAMPLE_BITS-1:0]  peak_mag [apm_pkg::CHANNELS];
  logic [apm_pkg::SEG_W-1:0]        hold_seg [apm_pkg::CHANNELS];
  logic [apm_pkg::AGE_W-1:0]        hold_age [apm_pkg::CHANNELS];
  logic signed [apm_pkg::LVL_W-1:0] ref_lvl = '0;
  logic [apm_pkg::AGE_W-1:0]        decay_lim = 8'd12;
  logic [apm_pkg::SEG_W-1:0]        width_seg = 6'd20;

  meter_item_t pending_q [$];
  reading_t    reading_q [$];
  meter_item_t next_item;
  meter_item_t taken_item;
  reading_t    got_rd;
  reading_t    exp_rd;

  int  tx_gap = 0;
  int  rx_wait = 0;
  int  rx_next;
  int  fail_cnt = 0;
  bit  tx_idle_en = 1'b0;
  bit  rx_idle_en = 1'b0;
  logic rx_hold = 1'b0;

  audio_peak_meter_iec_scale_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (in_func),
    .channel_i       (in_chan),
    .sample_i        (in_sample),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_channel_o   (out_chan),
    .level_db_o      (level_db),
    .bar_length_o    (bar_len),
    .hold_position_o (hold_pos)
  );

  always #4 clk = ~clk;

  initial begin
    for (int i = 0; i < apm_pkg::CHANNELS; i++) begin
      peak_mag[i] = '0;
      hold_seg[i] = '0;
      hold_age[i] = '0;
    end
  end

  function automatic int level_db16(logic [apm_pkg::SAMPLE_BITS-1:0] p);
    int e = 0;
    int unsigned pv;
    int unsigned m;
    pv = 32'(p);
    if (pv == 0) return -2048;
    while (e < 31 && (pv >> (e + 1)) != 0) e++;
    if (e >= 5) m = (pv >> (e - 5)) & 31;
    else m = (pv << (5 - e)) & 31;
    return ((e - (apm_pkg::SAMPLE_BITS - 1)) * 1541 + log_db256[m]) >>> 4;
  endfunction

  // IEC deflection in 1/64 percent
  function automatic int deflection_64th(int d);
    if (d < -1120) return 0;
    else if (d < -960) return d + 1120;
    else if (d < -800) return (d + 960) * 2 + 160;
    else if (d < -640) return (d + 800) * 3 + 480;
    else if (d < -480) return (d + 640) * 6 + 960;
    else if (d < -320) return (d + 480) * 8 + 1920;
    else if (d < 0) return (d + 320) * 10 + 3200;
    return 6400;
  endfunction

  task automatic meter_update(meter_item_t it);
    int c;
    int s;
    int lvl;
    int bar;
    reading_t r;
    c = int'(it.ch);
    if (it.func == apm_pkg::FUNC_SAMPLE) begin
      s = {{(32-apm_pkg::SAMPLE_BITS){it.sample[apm_pkg::SAMPLE_BITS-1]}}, it.sample};
      if (s < 0) s = -s;
      if (s > int'(peak_mag[c])) peak_mag[c] = s[apm_pkg::SAMPLE_BITS-1:0];
    end else begin
      lvl = level_db16(peak_mag[c]) - int'(ref_lvl);
      peak_mag[c] = '0;
      if (lvl < -2048) lvl = -2048;
      if (lvl > 2047) lvl = 2047;
      bar = (deflection_64th(lvl) * int'(width_seg)) / 6400;
      if (bar > int'(hold_seg[c])) begin
        hold_seg[c] = bar[apm_pkg::SEG_W-1:0];
        hold_age[c] = '0;
      end else begin
        if (hold_age[c] > decay_lim) hold_seg[c] = bar[apm_pkg::SEG_W-1:0];
        if (hold_age[c] != '1) hold_age[c] = hold_age[c] + 1'b1;
      end
      r.ch = it.ch;
      r.lvl = lvl[apm_pkg::LVL_W-1:0];
      r.bar = bar[apm_pkg::SEG_W-1:0];
      r.hold = (hold_seg[c] > width_seg) ? width_seg : hold_seg[c];
      reading_q.push_back(r);
    end
  endtask

  task automatic note_fail(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("ERROR %0t: %s", $realtime, msg);
  endtask

  // item driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        taken_item = {in_func, in_chan, in_sample};
        meter_update(taken_item);
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          next_item = pending_q.pop_front();
          in_func <= next_item.func;
          in_chan <= next_item.ch;
          in_sample <= next_item.sample;
          in_valid <= 1'b1;
          tx_gap <= tx_idle_en ? int'($urandom_range(0, 13)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // reading monitor and result-side stall
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got_rd = {out_chan, level_db, bar_len, hold_pos};
        if (reading_q.size() == 0) begin
          note_fail($sformatf("unexpected reading ch=%0d lvl=%0d bar=%0d hold=%0d",
                              got_rd.ch, got_rd.lvl, got_rd.bar, got_rd.hold));
        end else begin
          exp_rd = reading_q.pop_front();
          if (got_rd.ch !== exp_rd.ch || got_rd.lvl !== exp_rd.lvl ||
              got_rd.bar !== exp_rd.bar || got_rd.hold !== exp_rd.hold)
            note_fail($sformatf(
              {"reading mismatch exp ch=%0d lvl=%0d bar=%0d hold=%0d",
               " got ch=%0d lvl=%0d bar=%0d hold=%0d"},
              exp_rd.ch, exp_rd.lvl, exp_rd.bar, exp_rd.hold,
              got_rd.ch, got_rd.lvl, got_rd.bar, got_rd.hold));
        end
        rx_next = rx_idle_en ? int'($urandom_range(0, 13)) : 0;
      end else begin
        rx_next = (rx_wait > 0) ? rx_wait - 1 : 0;
      end
      rx_wait <= rx_next;
      out_stall <= rx_hold || (rx_next > 0);
    end
  end

  task automatic push_item(logic f, int c, int s);
    meter_item_t it;
    it.func = f;
    it.ch = c[apm_pkg::CH_W-1:0];
    it.sample = s[apm_pkg::SAMPLE_BITS-1:0];
    pending_q.push_back(it);
  endtask

  function automatic int rand_sample();
    logic [apm_pkg::SAMPLE_BITS-1:0] v;
    int k;
    v = apm_pkg::SAMPLE_BITS'($urandom);
    k = int'($urandom_range(0, apm_pkg::SAMPLE_BITS));
    case ($urandom_range(0, 9))
      0: return -(1 << (apm_pkg::SAMPLE_BITS - 1));
      1: return (1 << (apm_pkg::SAMPLE_BITS - 1)) - 1;
      2: return $urandom_range(0, 1) ? 1 : -1;
      default: begin
        v = v >> (apm_pkg::SAMPLE_BITS - k);
        if ($urandom_range(0, 1)) v = -v;
        return {{(32-apm_pkg::SAMPLE_BITS){v[apm_pkg::SAMPLE_BITS-1]}}, v};
      end
    endcase
  endfunction

  // bursts of samples closed by a tick; some ticks alone, some stray samples
  task automatic push_bursts(int n_items);
    int cnt = 0;
    int c;
    int n;
    while (cnt < n_items) begin
      c = int'($urandom_range(0, apm_pkg::CHANNELS - 1));
      n = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 6));
      for (int i = 0; i < n; i++)
        push_item(apm_pkg::FUNC_SAMPLE, ($urandom_range(0, 5) == 0) ? 1 - c : c,
                  rand_sample());
      push_item(apm_pkg::FUNC_TICK, c, $urandom);
      cnt += n + 1;
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_q.size() != 0 || in_valid || reading_q.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [apm_pkg::CFG_IDX_W-1:0] idx,
                           logic [apm_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      apm_pkg::CFG_REF_LEVEL:   ref_lvl = data[apm_pkg::LVL_W-1:0];
      apm_pkg::CFG_DECAY_TICKS: decay_lim = data[apm_pkg::AGE_W-1:0];
      apm_pkg::CFG_METER_WIDTH: width_seg = data[apm_pkg::SEG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_meter(int rl, int dk, int w);
    logic [apm_pkg::CFG_DATA_W-1:0] junk;
    junk = apm_pkg::CFG_DATA_W'($urandom);
    write_reg(apm_pkg::CFG_REF_LEVEL, rl[apm_pkg::CFG_DATA_W-1:0]);
    write_reg(apm_pkg::CFG_DECAY_TICKS,
              {junk[apm_pkg::CFG_DATA_W-1:apm_pkg::AGE_W], dk[apm_pkg::AGE_W-1:0]});
    junk = apm_pkg::CFG_DATA_W'($urandom);
    write_reg(apm_pkg::CFG_METER_WIDTH,
              {junk[apm_pkg::CFG_DATA_W-1:apm_pkg::SEG_W], w[apm_pkg::SEG_W-1:0]});
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero peaks, full scale both signs, tiny and mid values
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    push_item(apm_pkg::FUNC_TICK, 1, -1);
    push_item(apm_pkg::FUNC_SAMPLE, 0, 8388607);
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 1, -8388608);
    push_item(apm_pkg::FUNC_TICK, 1, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 0, 1);
    push_item(apm_pkg::FUNC_SAMPLE, 0, -1);
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 1, 0);
    push_item(apm_pkg::FUNC_TICK, 1, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 0, 'h1F);
    push_item(apm_pkg::FUNC_SAMPLE, 1, -'h400);
    push_item(apm_pkg::FUNC_SAMPLE, 0, -'h123456);
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    push_item(apm_pkg::FUNC_TICK, 1, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 0, -8388607);
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    push_item(apm_pkg::FUNC_SAMPLE, 1, 'h2AAAAA);
    push_item(apm_pkg::FUNC_SAMPLE, 1, 'h555555);
    push_item(apm_pkg::FUNC_TICK, 1, 0);
    push_item(apm_pkg::FUNC_TICK, 0, 0);
    wait_idle();

    // result side held off long enough to back up the input
    @(posedge clk);
    rx_hold <= 1'b1;
    for (int i = 0; i < 40; i++)
      push_item(($urandom_range(0, 2) == 0) ? apm_pkg::FUNC_SAMPLE : apm_pkg::FUNC_TICK,
                int'($urandom_range(0, apm_pkg::CHANNELS - 1)), rand_sample());
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_meter(-1024, 0, 63);
        1: set_meter(1024, 255, 1);
        2: set_meter(-2048, 1, 0);
        6: set_meter(0, 2, 50);
        default: set_meter($urandom_range(0, 2048) - 1024, $urandom_range(0, 255),
                           $urandom_range(1, 63));
      endcase
      tx_idle_en = (p % 3) != 0;
      rx_idle_en = (p % 2) != 0;
      push_bursts(50);
      // end loud so the next setting starts with high hold markers
      for (int c = 0; c < apm_pkg::CHANNELS; c++) begin
        push_item(apm_pkg::FUNC_SAMPLE, c, -8388608);
        push_item(apm_pkg::FUNC_TICK, c, 0);
      end
      wait_idle();
    end

    if (fail_cnt == 0 && reading_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
